>>> hw/rtl/mpq_pkg.sv
// Shared types and constants for the reservation priority queue.
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    // Number of record slots and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Operation codes on the input channel.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_LOAD,
        S_SHIFT,
        S_DONE
    } state_t;

    // One stored reservation record.
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
        logic [4:0]  end_hour;
        logic [5:0]  end_minute;
        logic [9:0]  min_capacity;
        logic [7:0]  resource_id;
        logic [7:0]  prio;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // Request to the shared minimum-search unit.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic [IDX_W-1:0] idx;
        logic [7:0]       prio;
    } min_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/mpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mpq_ram #(
    parameter int RAM_WIDTH = 8,
    parameter int RAM_DEPTH = 16,
    localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        wr_addr,
    input  logic [RAM_WIDTH-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [RAM_WIDTH-1:0] rd_data
);

    logic [RAM_WIDTH-1:0] mem [RAM_DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/mpq_min_unit.sv
// Shared comparator that tracks the earliest slot holding the smallest priority.
`timescale 1ns / 1ps
`default_nettype none

module mpq_min_unit (
    input  logic                    aclk,
    input  mpq_pkg::min_req_t       req,
    output logic [mpq_pkg::IDX_W-1:0] best_idx
);
    import mpq_pkg::*;

    logic [7:0]       best_prio_reg;
    logic [IDX_W-1:0] best_idx_reg;

    // A strictly smaller priority replaces the best, so ties keep the earlier slot.
    always_ff @(posedge aclk) begin
        if (req.valid && (req.first || (req.prio < best_prio_reg))) begin
            best_prio_reg <= req.prio;
            best_idx_reg  <= req.idx;
        end
    end

    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

>>> hw/rtl/min_priority_queue_fifo_ties.sv
// An insert or a rejected operation passes from acceptance through S_DONE to the result.
// A remove scans the held records, fetches the minimum, then shifts the records behind it:
// one record RAM read per cycle feeds a shared comparator, then the tail moves up one slot.
// One transaction at a time; the result register lets the next input in while it waits.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module min_priority_queue_fifo_ties (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [4:0]  s_day,
    input  logic [3:0]  s_month,
    input  logic [13:0] s_year,
    input  logic [4:0]  s_start_hour,
    input  logic [5:0]  s_start_minute,
    input  logic [4:0]  s_end_hour,
    input  logic [5:0]  s_end_minute,
    input  logic [9:0]  s_min_capacity,
    input  logic [7:0]  s_resource_id,
    input  logic [7:0]  s_priority_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_occupancy,
    output logic [4:0]  m_out_day,
    output logic [3:0]  m_out_month,
    output logic [13:0] m_out_year,
    output logic [4:0]  m_out_start_hour,
    output logic [5:0]  m_out_start_minute,
    output logic [4:0]  m_out_end_hour,
    output logic [5:0]  m_out_end_minute,
    output logic [9:0]  m_out_min_capacity,
    output logic [7:0]  m_out_resource_id,
    output logic [7:0]  m_out_priority
);
    import mpq_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    status_t           res_status_reg, res_status_next;
    rec_t              res_rec_reg, res_rec_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [4:0]        m_occ_reg, m_occ_next;
    rec_t              m_rec_reg, m_rec_next;

    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    rec_t              wr_data;
    logic [IDX_W-1:0]  rd_addr;
    rec_t              rd_data;
    rec_t              in_rec;
    min_req_t          min_req;
    logic [IDX_W-1:0]  best_idx;
    logic [CNT_W:0]    best_plus1;
    logic [CNT_W:0]    ptr_plus2;

    // Record storage.
    mpq_ram #(
        .RAM_WIDTH(REC_W),
        .RAM_DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared minimum search.
    mpq_min_unit u_min (
        .aclk     (aclk),
        .req      (min_req),
        .best_idx (best_idx)
    );

    // Incoming record.
    always_comb begin
        in_rec.day          = s_day;
        in_rec.month        = s_month;
        in_rec.year         = s_year;
        in_rec.start_hour   = s_start_hour;
        in_rec.start_minute = s_start_minute;
        in_rec.end_hour     = s_end_hour;
        in_rec.end_minute   = s_end_minute;
        in_rec.min_capacity = s_min_capacity;
        in_rec.resource_id  = s_resource_id;
        in_rec.prio         = s_priority_req;
    end

    assign best_plus1 = (CNT_W + 1)'(best_idx) + 1'b1;
    assign ptr_plus2  = {1'b0, ptr_reg} + (CNT_W + 1)'(2);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        m_status_reg   <= m_status_next;
        m_occ_reg      <= m_occ_next;
        m_rec_reg      <= m_rec_next;
    end

    // Sequencer: write an insert directly; for a remove, scan for the minimum, fetch it, then close the gap.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_occ_next      = m_occ_reg;
        m_rec_next      = m_rec_reg;
        we              = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        rd_addr         = '0;
        min_req         = '0;
        s_ready         = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_rec_next = '0;
                    if (s_op == OP_INSERT) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            res_status_next = ST_FULL;
                        end else begin
                            we              = 1'b1;
                            wr_addr         = count_reg[IDX_W-1:0];
                            wr_data         = in_rec;
                            count_next      = count_reg + 1'b1;
                            res_status_next = ST_INSERTED;
                        end
                        state_next = S_DONE;
                    end else if (count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                        state_next      = S_DONE;
                    end else begin
                        rd_addr    = '0;
                        ptr_next   = CNT_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Data read last cycle belongs to slot ptr_reg - 1.
                min_req.valid = 1'b1;
                min_req.first = (ptr_reg == CNT_W'(1));
                min_req.idx   = IDX_W'(ptr_reg - 1'b1);
                min_req.prio  = rd_data.prio;
                if (ptr_reg < count_reg) begin
                    rd_addr  = ptr_reg[IDX_W-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                rd_addr    = best_idx;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                res_rec_next    = rd_data;
                res_status_next = ST_REMOVED;
                if (best_plus1 < {1'b0, count_reg}) begin
                    rd_addr    = best_plus1[IDX_W-1:0];
                    ptr_next   = CNT_W'(best_idx);
                    state_next = S_SHIFT;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHIFT: begin
                // Move the record of slot ptr_reg + 1 down into slot ptr_reg.
                we       = 1'b1;
                wr_addr  = ptr_reg[IDX_W-1:0];
                wr_data  = rd_data;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_plus2 < {1'b0, count_reg}) begin
                    rd_addr = ptr_plus2[IDX_W-1:0];
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_occ_next    = 5'(count_reg);
                    m_rec_next    = res_rec_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result channel.
    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_occupancy        = m_occ_reg;
    assign m_out_day          = m_rec_reg.day;
    assign m_out_month        = m_rec_reg.month;
    assign m_out_year         = m_rec_reg.year;
    assign m_out_start_hour   = m_rec_reg.start_hour;
    assign m_out_start_minute = m_rec_reg.start_minute;
    assign m_out_end_hour     = m_rec_reg.end_hour;
    assign m_out_end_minute   = m_rec_reg.end_minute;
    assign m_out_min_capacity = m_rec_reg.min_capacity;
    assign m_out_resource_id  = m_rec_reg.resource_id;
    assign m_out_priority     = m_rec_reg.prio;

endmodule

`default_nettype wire

>>> hw/rtl/mpq_checker.sv
// Port-level checks for the reservation priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mpq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [4:0]  m_occupancy,
    input wire logic [4:0]  m_out_day,
    input wire logic [7:0]  m_out_priority
);
    import mpq_pkg::*;

    // A stalled transaction keeps its status.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");

    // A remove from an empty queue reports no records held.
    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> (m_occupancy == '0))
        else $error("empty result with nonzero occupancy");

    // A rejected insert reports a full queue.
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> (m_occupancy == 5'(DEPTH)))
        else $error("full result with wrong occupancy");

    // Only a remove that found a record carries record fields.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_REMOVED) |-> (m_out_day == '0) && (m_out_priority == '0))
        else $error("record fields set on a result without a removal");

    // A successful insert never reports an empty queue.
    a_insert_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_INSERTED) |-> (m_occupancy != '0))
        else $error("insert reported zero occupancy");

endmodule

bind min_priority_queue_fifo_ties mpq_checker u_mpq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_occupancy    (m_occupancy),
    .m_out_day      (m_out_day),
    .m_out_priority (m_out_priority)
);

`default_nettype wire
